// ----- sv/ghn_pkg.sv -----
// ----------------------------------------------------------------------------
// ghn_pkg: shared types and constants
// Widths, command codes and the bin store request bundle for the histogram.
// ----------------------------------------------------------------------------
package ghn_pkg;

  localparam int NUM_BINS    = 256;
  localparam int BIN_IDX_W   = $clog2(NUM_BINS);
  localparam int COUNT_W     = 24;
  localparam int HEIGHT_W    = 12;
  localparam int PROD_W      = COUNT_W + HEIGHT_W;
  localparam int DIV_CNT_W   = $clog2(HEIGHT_W);

  localparam logic [COUNT_W-1:0]  COUNT_MAX    = {COUNT_W{1'b1}};
  localparam logic [HEIGHT_W-1:0] LIMIT_RESET  = HEIGHT_W'(400);

  typedef enum logic [1:0] {
    CMD_COUNT = 2'd0,
    CMD_READ  = 2'd1,
    CMD_CLEAR = 2'd2,
    CMD_NONE  = 2'd3
  } cmd_t;

  typedef struct packed {
    logic                 rd_en;
    logic                 wr_en;
    logic                 clr;
    logic [BIN_IDX_W-1:0] addr;
    logic [COUNT_W-1:0]   wr_data;
  } store_req_t;

endpackage

// ----- sv/ghn_bin_store.sv -----
// ----------------------------------------------------------------------------
// ghn_bin_store: bin count memory
// Single-port count memory with registered read and per-entry valid bits;
// an entry not written since the last clear reads as zero.
// ----------------------------------------------------------------------------
module ghn_bin_store (
  input  logic                         clk,
  input  logic                         rst_n,
  input  ghn_pkg::store_req_t          req,
  output logic [ghn_pkg::COUNT_W-1:0]  rd_data
);

  logic [ghn_pkg::COUNT_W-1:0]  mem [ghn_pkg::NUM_BINS];
  logic [ghn_pkg::NUM_BINS-1:0] valid_r;
  logic [ghn_pkg::COUNT_W-1:0]  data_r;
  logic                         hit_r;

  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem[req.addr] <= req.wr_data;
    end
    if (req.rd_en) begin
      data_r <= mem[req.addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
      hit_r   <= 1'b0;
    end else begin
      if (req.clr) begin
        valid_r <= '0;
      end else if (req.wr_en) begin
        valid_r[req.addr] <= 1'b1;
      end
      if (req.rd_en) begin
        hit_r <= valid_r[req.addr];
      end
    end
  end

  assign rd_data = hit_r ? data_r : '0;

endmodule

// ----- sv/ghn_divider.sv -----
// ----------------------------------------------------------------------------
// ghn_divider: restoring divider
// One quotient bit per cycle; the quotient is known to fit HEIGHT_W bits
// because the dividend is below divisor times 2^HEIGHT_W.
// ----------------------------------------------------------------------------
module ghn_divider (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  logic [ghn_pkg::PROD_W-1:0]    dividend,
  input  logic [ghn_pkg::COUNT_W-1:0]   divisor,
  output logic                          done,
  output logic [ghn_pkg::HEIGHT_W-1:0]  quotient
);

  logic                            run_r, run_nxt;
  logic                            done_r, done_nxt;
  logic [ghn_pkg::DIV_CNT_W-1:0]   cnt_r, cnt_nxt;
  logic [ghn_pkg::COUNT_W-1:0]     rem_r, rem_nxt;
  logic [ghn_pkg::HEIGHT_W-1:0]    low_r, low_nxt;
  logic [ghn_pkg::HEIGHT_W-1:0]    q_r, q_nxt;
  logic [ghn_pkg::COUNT_W-1:0]     div_r, div_nxt;
  logic [ghn_pkg::COUNT_W:0]       trial;
  logic                            ge;

  assign trial = {rem_r, low_r[ghn_pkg::HEIGHT_W-1]};
  assign ge    = trial >= {1'b0, div_r};

  always_comb begin
    run_nxt  = run_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    low_nxt  = low_r;
    q_nxt    = q_r;
    div_nxt  = div_r;
    if (start) begin
      run_nxt = 1'b1;
      cnt_nxt = '0;
      rem_nxt = dividend[ghn_pkg::PROD_W-1:ghn_pkg::HEIGHT_W];
      low_nxt = dividend[ghn_pkg::HEIGHT_W-1:0];
      div_nxt = divisor;
      q_nxt   = '0;
    end else if (run_r) begin
      rem_nxt = ge ? trial[ghn_pkg::COUNT_W-1:0] - div_r : trial[ghn_pkg::COUNT_W-1:0];
      low_nxt = {low_r[ghn_pkg::HEIGHT_W-2:0], 1'b0};
      q_nxt   = {q_r[ghn_pkg::HEIGHT_W-2:0], ge};
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == ghn_pkg::DIV_CNT_W'(ghn_pkg::HEIGHT_W - 1)) begin
        run_nxt  = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      run_r  <= run_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    rem_r <= rem_nxt;
    low_r <= low_nxt;
    q_r   <= q_nxt;
    div_r <= div_nxt;
  end

  assign done     = done_r;
  assign quotient = q_r;

endmodule

// ----- sv/gray_histogram_normalizer.sv -----
// ----------------------------------------------------------------------------
// gray_histogram_normalizer: 256-bin gray histogram with peak-scaled read-out
// Counts pixels into saturating bins, tracks the peak bin count, and answers reads
// with the raw count and floor(count * bar_height_limit / peak).
//
//   channel  ports                          handshake
//   input    in_command, in_value           start && !busy
//   result   out_bin_count, out_bar_height,  out_strobe, one cycle
//            out_peak_count
//   config   cfg_wr_data                    cfg_wr_en
//
// A count item passes through accept, memory read and write back.
// A read item passes through accept, memory read, multiply, divider load,
// the bit-serial divider and a result step; the strobe follows.
// A clear item is done at accept; valid bits clear all bins at once.
// Synchronous active-low reset clears all bins, the peak and sets the limit
// to 400. The receiver cannot stall; each result strobe stands for one cycle.
// ----------------------------------------------------------------------------
module gray_histogram_normalizer (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  output logic                          busy,
  input  logic [1:0]                    in_command,
  input  logic [7:0]                    in_value,
  output logic                          out_strobe,
  output logic [ghn_pkg::COUNT_W-1:0]   out_bin_count,
  output logic [ghn_pkg::HEIGHT_W-1:0]  out_bar_height,
  output logic [ghn_pkg::COUNT_W-1:0]   out_peak_count,
  input  logic                          cfg_wr_en,
  input  logic [ghn_pkg::HEIGHT_W-1:0]  cfg_wr_data
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_FETCH,
    S_COUNT,
    S_MUL,
    S_DSTART,
    S_DIV
  } state_t;

  state_t                          state_r, state_nxt;
  ghn_pkg::cmd_t                   cmd_r, cmd_nxt;
  logic [ghn_pkg::BIN_IDX_W-1:0]   idx_r, idx_nxt;
  logic [ghn_pkg::COUNT_W-1:0]     peak_r, peak_nxt;
  logic [ghn_pkg::HEIGHT_W-1:0]    limit_r;
  logic [ghn_pkg::COUNT_W-1:0]     cnt_r, cnt_nxt;
  logic [ghn_pkg::PROD_W-1:0]      prod_r, prod_nxt;
  logic                            strobe_r, strobe_nxt;
  logic [ghn_pkg::COUNT_W-1:0]     obin_r, obin_nxt;
  logic [ghn_pkg::HEIGHT_W-1:0]    obar_r, obar_nxt;
  logic [ghn_pkg::COUNT_W-1:0]     opeak_r, opeak_nxt;

  ghn_pkg::store_req_t             req;
  logic [ghn_pkg::COUNT_W-1:0]     rd_data;
  logic [ghn_pkg::COUNT_W-1:0]     inc;
  logic                            accept;
  logic                            div_start;
  logic                            div_done;
  logic [ghn_pkg::HEIGHT_W-1:0]    div_q;

  assign accept = start && !busy;
  assign inc    = (rd_data == ghn_pkg::COUNT_MAX) ? rd_data : rd_data + 1'b1;

  ghn_bin_store u_store (
    .clk     (clk),
    .rst_n   (rst_n),
    .req     (req),
    .rd_data (rd_data)
  );

  ghn_divider u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (prod_r),
    .divisor  (peak_r),
    .done     (div_done),
    .quotient (div_q)
  );

  always_comb begin
    state_nxt  = state_r;
    cmd_nxt    = cmd_r;
    idx_nxt    = idx_r;
    peak_nxt   = peak_r;
    cnt_nxt    = cnt_r;
    prod_nxt   = prod_r;
    strobe_nxt = 1'b0;
    obin_nxt   = obin_r;
    obar_nxt   = obar_r;
    opeak_nxt  = opeak_r;
    div_start  = 1'b0;
    req.rd_en   = 1'b0;
    req.wr_en   = 1'b0;
    req.clr     = 1'b0;
    req.addr    = idx_r;
    req.wr_data = inc;
    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          cmd_nxt = ghn_pkg::cmd_t'(in_command);
          idx_nxt = in_value;
          unique case (ghn_pkg::cmd_t'(in_command))
            ghn_pkg::CMD_COUNT, ghn_pkg::CMD_READ: state_nxt = S_FETCH;
            ghn_pkg::CMD_CLEAR: begin
              req.clr  = 1'b1;
              peak_nxt = '0;
            end
            default: ;
          endcase
        end
      end
      S_FETCH: begin
        req.rd_en = 1'b1;
        state_nxt = (cmd_r == ghn_pkg::CMD_COUNT) ? S_COUNT : S_MUL;
      end
      S_COUNT: begin
        req.wr_en = 1'b1;
        if (inc > peak_r) begin
          peak_nxt = inc;
        end
        state_nxt = S_IDLE;
      end
      S_MUL: begin
        cnt_nxt   = rd_data;
        prod_nxt  = ghn_pkg::PROD_W'(rd_data) * ghn_pkg::PROD_W'(limit_r);
        state_nxt = S_DSTART;
      end
      S_DSTART: begin
        div_start = 1'b1;
        state_nxt = S_DIV;
      end
      S_DIV: begin
        if (div_done) begin
          strobe_nxt = 1'b1;
          obin_nxt   = cnt_r;
          obar_nxt   = (peak_r == '0) ? '0 : div_q;
          opeak_nxt  = peak_r;
          state_nxt  = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      peak_r   <= '0;
      limit_r  <= ghn_pkg::LIMIT_RESET;
      strobe_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      peak_r   <= peak_nxt;
      strobe_r <= strobe_nxt;
      if (cfg_wr_en) begin
        limit_r <= cfg_wr_data;
      end
    end
    cmd_r   <= cmd_nxt;
    idx_r   <= idx_nxt;
    cnt_r   <= cnt_nxt;
    prod_r  <= prod_nxt;
    obin_r  <= obin_nxt;
    obar_r  <= obar_nxt;
    opeak_r <= opeak_nxt;
  end

  assign busy           = (state_r != S_IDLE);
  assign out_strobe     = strobe_r;
  assign out_bin_count  = obin_r;
  assign out_bar_height = obar_r;
  assign out_peak_count = opeak_r;

  a_fetch_after_count: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && (in_command == ghn_pkg::CMD_COUNT)) |=> busy)
    else $error("count item did not start a fetch");

  a_strobe_from_div: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> $past(div_done))
    else $error("result strobe without divider completion");

  a_count_le_peak: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> (out_bin_count <= out_peak_count))
    else $error("bin count above peak");

  a_zero_peak_height: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && (out_peak_count == '0)) |-> (out_bar_height == '0))
    else $error("nonzero height with zero peak");

  a_single_strobe: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |=> !out_strobe)
    else $error("result strobe held for two cycles");

endmodule
